// File: rtl/core/rfp_pkg.sv
// Shared constants and helpers for the remote frame parser.
`default_nettype none

package rfp_pkg;

    // Frame format
    localparam logic [7:0]  SYNC_BYTE   = 8'h55;
    localparam logic [3:0]  LEN_MAX     = 4'hC;
    localparam logic [7:0]  FLAG_SPEED  = 8'h10;
    localparam logic [7:0]  FLAG_CMD    = 8'h20;
    localparam logic [7:0]  CMD_PRESET_LO = 8'h01;
    localparam logic [7:0]  CMD_PRESET_HI = 8'h07;
    localparam logic [7:0]  CMD_LIGHT_ON  = 8'h08;
    localparam logic [7:0]  CMD_WATER     = 8'h0A;
    localparam logic [7:0]  CSUM_MOD      = 8'hFF;

    // Payload store
    localparam int STORE_DEPTH = 16;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Timer
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    // Parser phases
    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_PAY   = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    // Input beat kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result kinds
    localparam logic [2:0] RK_SPEED  = 3'd0;
    localparam logic [2:0] RK_PRESET = 3'd1;
    localparam logic [2:0] RK_STOP   = 3'd5;

    typedef logic [7:0] t_byte;

    // Reduce a 12-bit running sum modulo 255 (256 is 1 mod 255)
    function automatic t_byte mod255(input logic [11:0] sum);
        logic [8:0] fold;
        begin
            fold = {5'd0, sum[11:8]} + {1'b0, sum[7:0]};
            if (fold >= {1'b0, CSUM_MOD}) begin
                fold = fold - {1'b0, CSUM_MOD};
            end
            mod255 = fold[7:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/remote_frame_parser_top.sv
// Remote frame parser: sync hunt, checksum check, command decode and stop timer.
// A result appears in the output register in the cycle after its beat is accepted.
// Throughput: one input beat per cycle; a beat is taken even while a result waits, as long
// as that result leaves in the same cycle. Each beat yields at most one result.
// Reset (i_rst_n low, synchronous) clears the parser, the payload store, the timer and
// the output valid, and sets r_timeout to 10.
`default_nettype none

module remote_frame_parser_top import rfp_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_kind,
    input  wire  [7:0]  i_byte_value,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_speed_word_x,
    output logic [31:0] o_speed_word_y,
    output logic [31:0] o_speed_word_z,
    output logic [2:0]  o_preset_code,
    // configuration channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_data
);

    logic [15:0]       r_timeout;
    logic [1:0]        r_phase,     n_phase;
    logic [STORE_AW-1:0] r_bytes_taken, n_bytes_taken;
    logic [3:0]        r_exp_len,   n_exp_len;
    logic [11:0]       r_sum,       n_sum;
    t_byte             r_store [STORE_DEPTH];
    logic              n_store_we;
    logic [15:0]       r_countdown, n_countdown;
    logic              r_motion,    n_motion;

    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_kind,  n_out_kind;
    logic [31:0]       r_word_x,    n_word_x;
    logic [31:0]       r_word_y,    n_word_y;
    logic [31:0]       r_word_z,    n_word_z;
    logic [2:0]        r_preset,    n_preset;

    logic              w_in_acc;
    logic              w_out_free;
    logic [STORE_AW:0] w_taken_next;
    logic [11:0]       w_sum_add;
    t_byte             w_type;
    t_byte             w_code;

    // Handshakes
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_out_free;
    assign w_in_acc   = i_in_valid && w_out_free;
    assign o_cfg_ready = 1'b1;

    assign w_taken_next = {1'b0, r_bytes_taken} + {{STORE_AW{1'b0}}, 1'b1};
    assign w_sum_add    = r_sum + {4'd0, i_byte_value};
    assign w_type       = r_store[0];
    assign w_code       = r_store[1];

    // Parse one beat
    always_comb begin
        n_phase       = r_phase;
        n_bytes_taken = r_bytes_taken;
        n_exp_len     = r_exp_len;
        n_sum         = r_sum;
        n_store_we    = 1'b0;
        n_countdown   = r_countdown;
        n_motion      = r_motion;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_kind    = r_out_kind;
        n_word_x      = r_word_x;
        n_word_y      = r_word_y;
        n_word_z      = r_word_z;
        n_preset      = r_preset;

        if (w_in_acc) begin
            n_out_kind = RK_STOP;
            n_word_x   = '0;
            n_word_y   = '0;
            n_word_z   = '0;
            n_preset   = '0;
            if (i_kind == KIND_TICK) begin
                // advance the stop timer
                if (r_motion) begin
                    if (r_countdown == 16'd0) begin
                        n_motion    = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_kind  = RK_STOP;
                    end else begin
                        n_countdown = r_countdown - 16'd1;
                    end
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_byte_value == SYNC_BYTE) begin
                            n_phase       = PH_LEN;
                            n_bytes_taken = '0;
                            n_exp_len     = '0;
                            n_sum         = {4'd0, SYNC_BYTE};
                        end
                    end
                    PH_LEN: begin
                        if (i_byte_value[3:0] <= LEN_MAX) begin
                            n_store_we    = 1'b1;
                            n_bytes_taken = w_taken_next[STORE_AW-1:0];
                            n_sum         = w_sum_add;
                            n_exp_len     = i_byte_value[3:0];
                            n_phase       = PH_PAY;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_PAY: begin
                        n_store_we    = 1'b1;
                        n_bytes_taken = w_taken_next[STORE_AW-1:0];
                        n_sum         = w_sum_add;
                        if ({1'b0, w_taken_next[STORE_AW-1:0]} >=
                            ({1'b0, r_exp_len} + 5'd1)) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    default: begin
                        // check the sum, then decode the frame
                        n_phase = PH_HUNT;
                        if (mod255(r_sum) == i_byte_value) begin
                            n_sum = '0;
                            if ((w_type & FLAG_SPEED) != 8'd0) begin
                                n_countdown = r_timeout;
                                n_motion    = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_kind  = RK_SPEED;
                                n_word_x = {r_store[4], r_store[3], r_store[2], r_store[1]};
                                n_word_y = {r_store[8], r_store[7], r_store[6], r_store[5]};
                                n_word_z = {r_store[12], r_store[11], r_store[10], r_store[9]};
                            end else if ((w_type & FLAG_CMD) != 8'd0) begin
                                if (w_code >= CMD_PRESET_LO && w_code <= CMD_PRESET_HI) begin
                                    n_countdown = r_timeout;
                                    n_motion    = 1'b1;
                                    n_out_valid = 1'b1;
                                    n_out_kind  = RK_PRESET;
                                    n_preset    = w_code[2:0];
                                end else if (w_code >= CMD_LIGHT_ON && w_code <= CMD_WATER) begin
                                    n_out_valid = 1'b1;
                                    n_out_kind  = w_code[2:0] - 3'd6;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_bytes_taken <= '0;
            r_exp_len     <= '0;
            r_sum         <= '0;
            r_countdown   <= '0;
            r_motion      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_timeout     <= TIMEOUT_RESET;
        end else begin
            r_phase       <= n_phase;
            r_bytes_taken <= n_bytes_taken;
            r_exp_len     <= n_exp_len;
            r_sum         <= n_sum;
            r_countdown   <= n_countdown;
            r_motion      <= n_motion;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Write the payload store; reset clears every entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (n_store_we) begin
            r_store[r_bytes_taken] <= i_byte_value;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_word_x   <= n_word_x;
        r_word_y   <= n_word_y;
        r_word_z   <= n_word_z;
        r_preset   <= n_preset;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_speed_word_x = r_word_x;
    assign o_speed_word_y = r_word_y;
    assign o_speed_word_z = r_word_z;
    assign o_preset_code  = r_preset;

    // A tick never moves the parser
    a_tick_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind == KIND_TICK) |=> $stable(r_phase))
        else $error("parser phase changed on a tick beat");

    // Payload count stays within the announced length
    a_pay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> ({1'b0, r_bytes_taken} <= ({1'b0, r_exp_len} + 5'd1)))
        else $error("payload count ran past the length");

    // Timer expiry always shows up as a stop result
    a_stop_on_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_motion)) |-> (r_out_valid && r_out_kind == RK_STOP))
        else $error("timer expired without a stop result");

    // Only speed results carry words, only presets carry a code
    a_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != RK_SPEED) |->
            (r_word_x == 32'd0 && r_word_y == 32'd0 && r_word_z == 32'd0 &&
             (r_out_kind == RK_PRESET || r_preset == 3'd0)))
        else $error("result carries stray fields");

endmodule

`default_nettype wire
